### src/abl_pkg.sv
// Shared constants and types for the adaptive batch limit controller.
package abl_pkg;

    localparam int TX_W    = 16;
    localparam int BYTES_W = 32;
    localparam int AGE_W   = 32;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int PRESS_W = 2;
    localparam int PROD_W  = BYTES_W + TX_W;

    localparam int DIV_STEPS = BYTES_W;
    localparam int MUL_STEPS = TX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MAX_TX    = 3'd0;
    localparam t_cfg_idx CFG_MAX_BYTES = 3'd1;
    localparam t_cfg_idx CFG_MAX_AGE   = 3'd2;
    localparam t_cfg_idx CFG_LATENCY   = 3'd3;
    localparam t_cfg_idx CFG_MIN_LOAD  = 3'd4;
    localparam t_cfg_idx CFG_DEEP      = 3'd5;

    localparam logic [TX_W-1:0]    RST_MAX_TX    = 16'd64;
    localparam logic [BYTES_W-1:0] RST_MAX_BYTES = 32'd4194304;
    localparam logic [AGE_W-1:0]   RST_MAX_AGE   = 32'd100;
    localparam logic [AGE_W-1:0]   RST_LATENCY   = 32'd1000;
    localparam logic [TX_W-1:0]    RST_MIN_LOAD  = 16'd4;
    localparam logic [TX_W-1:0]    RST_DEEP      = 16'd16;

    localparam logic [BYTES_W-1:0] HARD_BYTES_CAP = 32'd524288;
    localparam logic [AGE_W-1:0]   SOFT_AGE_CAP   = 32'd50;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_LIMITS  = 1'b1;

    localparam logic [PRESS_W-1:0] PRESS_SOFT = 2'd1;
    localparam int                 PRESS_HARD_BIT = 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage

### src/adaptive_batch_limit_controller_unit.sv
// Adaptive batch limit controller: EWMA of bytes per transaction and epoch limit sizing.
//
//   channel   handshake                  payload
//   command   i_start / o_busy           i_command, i_observed_*, i_pressure,
//                                        i_queue_depth, i_oldest_age
//   result    o_done (one-cycle strobe)  o_limit_transactions, o_limit_bytes, o_limit_age
//   config    i_cfg_we                   i_cfg_addr, i_cfg_data
//
// An observe beat with a nonzero count runs a bit-serial restoring divider, one quotient bit
// per cycle, then blends the average in S_FIN; a zero count leaves o_busy low.
// A limits beat that needs the average runs a 16-step shift-add multiplier and then a clamp
// step in S_FIN; other limits beats give their result in the cycle after acceptance.
// Reset is synchronous, active low, and clears the average and loads register defaults.
// Results cannot be stalled; a new beat is taken as soon as o_busy falls.
module adaptive_batch_limit_controller_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_command,
    input  logic [abl_pkg::TX_W-1:0]       i_observed_transactions,
    input  logic [abl_pkg::BYTES_W-1:0]    i_observed_bytes,
    input  logic [abl_pkg::PRESS_W-1:0]    i_pressure,
    input  logic [abl_pkg::TX_W-1:0]       i_queue_depth,
    input  logic [abl_pkg::AGE_W-1:0]      i_oldest_age,
    output logic                           o_done,
    output logic [abl_pkg::TX_W-1:0]       o_limit_transactions,
    output logic [abl_pkg::BYTES_W-1:0]    o_limit_bytes,
    output logic [abl_pkg::AGE_W-1:0]      o_limit_age,
    input  logic                           i_cfg_we,
    input  logic [abl_pkg::IDX_W-1:0]      i_cfg_addr,
    input  logic [abl_pkg::CFG_W-1:0]      i_cfg_data
);
    import abl_pkg::*;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);

    t_state              r_state;
    logic                r_cmd;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [BYTES_W-1:0]  r_avg;

    logic [TX_W-1:0]     r_max_tx;
    logic [BYTES_W-1:0]  r_max_bytes;
    logic [AGE_W-1:0]    r_max_age;
    logic [AGE_W-1:0]    r_latency;
    logic [TX_W-1:0]     r_min_load;
    logic [TX_W-1:0]     r_deep;

    // datapath registers
    logic [BYTES_W-1:0]  r_quo;
    logic [TX_W-1:0]     r_rem;
    logic [TX_W-1:0]     r_div;
    logic [PROD_W-1:0]   r_prod;
    logic [TX_W-1:0]     r_ltx;
    logic [AGE_W-1:0]    r_lage;
    logic [TX_W-1:0]     r_out_tx;
    logic [BYTES_W-1:0]  r_out_bytes;
    logic [AGE_W-1:0]    r_out_age;

    logic                accept;
    logic [TX_W-1:0]     mtx;
    logic [BYTES_W-1:0]  mbytes;
    logic [AGE_W-1:0]    lat;
    logic [TX_W-1:0]     mload_raw;
    logic [TX_W-1:0]     mload;
    logic [TX_W-1:0]     deep_th;
    logic [BYTES_W-1:0]  mbytes_half;
    logic [TX_W-1:0]     mtx_half;
    logic                deep;
    logic                late;
    logic [TX_W-1:0]     depth_fl;
    logic [TX_W-1:0]     t0;
    logic [TX_W-1:0]     t0_half;
    logic [TX_W-1:0]     n_ltx;
    logic [BYTES_W-1:0]  n_lbytes;
    logic [AGE_W-1:0]    n_lage;
    logic                n_use_mul;

    logic [TX_W:0]       div_trial;
    logic                div_fit;
    logic [TX_W:0]       div_diff;
    logic [BYTES_W:0]    mul_sum;
    logic [BYTES_W-1:0]  prod_cap;
    logic [BYTES_W-1:0]  n_avg;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_limit_transactions = r_out_tx;
    assign o_limit_bytes        = r_out_bytes;
    assign o_limit_age          = r_out_age;

    // effective register values
    always_comb begin
        mtx       = (r_max_tx == '0) ? TX_W'(1) : r_max_tx;
        mbytes    = (r_max_bytes == '0) ? BYTES_W'(1) : r_max_bytes;
        lat       = (r_latency == '0) ? AGE_W'(1) : r_latency;
        deep_th   = (r_deep == '0) ? TX_W'(1) : r_deep;
        mload_raw = (r_min_load == '0) ? TX_W'(1) : r_min_load;
        mload     = (mload_raw > mtx) ? mtx : mload_raw;
        mtx_half    = (mtx >> 1) == '0 ? TX_W'(1) : (mtx >> 1);
        mbytes_half = (mbytes >> 1) == '0 ? BYTES_W'(1) : (mbytes >> 1);
    end

    // limits decision, settled in the accept cycle
    always_comb begin
        deep      = (i_queue_depth >= deep_th);
        late      = (i_oldest_age > lat);
        depth_fl  = (i_queue_depth > mload) ? i_queue_depth : mload;
        t0        = deep ? mtx : ((depth_fl < mtx) ? depth_fl : mtx);
        t0_half   = t0 >> 1;
        n_use_mul = 1'b0;
        n_ltx     = t0;
        n_lbytes  = mbytes;
        n_lage    = r_max_age;
        if (i_pressure[PRESS_HARD_BIT]) begin
            n_ltx    = TX_W'(1);
            n_lbytes = (mbytes < HARD_BYTES_CAP) ? mbytes : HARD_BYTES_CAP;
            n_lage   = '0;
        end else if (i_pressure == PRESS_SOFT) begin
            n_ltx    = mtx_half;
            n_lbytes = mbytes_half;
            n_lage   = (r_max_age < SOFT_AGE_CAP) ? r_max_age : SOFT_AGE_CAP;
        end else if (i_queue_depth <= TX_W'(1)) begin
            n_ltx    = TX_W'(1);
            n_lbytes = mbytes;
            n_lage   = late ? '0 : r_max_age;
        end else begin
            n_use_mul = (r_avg != '0);
            if (late) begin
                n_ltx    = (t0_half > mload) ? t0_half : mload;
                n_lbytes = mbytes_half;
                n_lage   = '0;
            end else begin
                n_ltx    = t0;
                n_lbytes = mbytes;
                n_lage   = (deep || (i_queue_depth >= t0)) ? '0 : r_max_age;
            end
        end
    end

    // one divider step, one multiplier step, final clamp and average blend
    always_comb begin
        div_trial = {r_rem, r_quo[BYTES_W-1]};
        div_fit   = (div_trial >= {1'b0, r_div});
        div_diff  = div_trial - {1'b0, r_div};
        mul_sum   = {1'b0, r_prod[PROD_W-1:TX_W]} + (r_prod[0] ? {1'b0, r_avg} : '0);
        if (r_prod > PROD_W'(mbytes)) begin
            prod_cap = mbytes;
        end else begin
            prod_cap = r_prod[BYTES_W-1:0];
        end
        if (prod_cap == '0) begin
            prod_cap = BYTES_W'(1);
        end
        if (r_avg == '0) begin
            n_avg = r_quo;
        end else begin
            n_avg = r_avg - {3'b0, r_avg[BYTES_W-1:3]} + {3'b0, r_quo[BYTES_W-1:3]};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= CMD_OBSERVE;
            r_done      <= 1'b0;
            r_cnt       <= '0;
            r_avg       <= '0;
            r_max_tx    <= RST_MAX_TX;
            r_max_bytes <= RST_MAX_BYTES;
            r_max_age   <= RST_MAX_AGE;
            r_latency   <= RST_LATENCY;
            r_min_load  <= RST_MIN_LOAD;
            r_deep      <= RST_DEEP;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAX_TX:    r_max_tx    <= i_cfg_data[TX_W-1:0];
                    CFG_MAX_BYTES: r_max_bytes <= i_cfg_data[BYTES_W-1:0];
                    CFG_MAX_AGE:   r_max_age   <= i_cfg_data[AGE_W-1:0];
                    CFG_LATENCY:   r_latency   <= i_cfg_data[AGE_W-1:0];
                    CFG_MIN_LOAD:  r_min_load  <= i_cfg_data[TX_W-1:0];
                    CFG_DEEP:      r_deep      <= i_cfg_data[TX_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept) begin
                        r_cmd <= i_command;
                        if (i_command == CMD_OBSERVE) begin
                            // drop epochs with no transactions
                            if (i_observed_transactions != '0) begin
                                r_state <= S_DIV;
                            end
                        end else if (n_use_mul) begin
                            r_state <= S_MUL;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == MUL_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    if (r_cmd == CMD_LIMITS) begin
                        r_done <= 1'b1;
                    end else begin
                        r_avg <= n_avg;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_quo  <= i_observed_bytes;
                r_rem  <= '0;
                r_div  <= i_observed_transactions;
                r_prod <= {{BYTES_W{1'b0}}, n_ltx};
                r_ltx  <= n_ltx;
                r_lage <= n_lage;
                if (accept && i_command == CMD_LIMITS && !n_use_mul) begin
                    r_out_tx    <= n_ltx;
                    r_out_bytes <= n_lbytes;
                    r_out_age   <= n_lage;
                end
            end
            S_DIV: begin
                // shift the next dividend bit into the remainder, the quotient bit into r_quo
                r_rem <= div_fit ? div_diff[TX_W-1:0] : div_trial[TX_W-1:0];
                r_quo <= {r_quo[BYTES_W-2:0], div_fit};
            end
            S_MUL: begin
                r_prod <= {mul_sum, r_prod[TX_W-1:1]};
            end
            S_FIN: begin
                if (r_cmd == CMD_LIMITS) begin
                    r_out_tx    <= r_ltx;
                    r_out_bytes <= prod_cap;
                    r_out_age   <= r_lage;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_div_is_observe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cmd == CMD_OBSERVE))
        else $error("divider running on a limits beat");

    a_mul_is_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cmd == CMD_LIMITS))
        else $error("multiplier running on an observe beat");

    a_observe_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_OBSERVE) |=> !o_done)
        else $error("observe beat produced a result");

    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_limit_transactions != '0 && o_limit_bytes != '0))
        else $error("zero limit on result");

    a_done_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobe while busy");
`endif

endmodule

### tb/sv/abl_limit_check.sv
// Result checker for the adaptive batch limit controller: predicts and compares limits beats.
module abl_limit_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_command,
    input  logic [abl_pkg::TX_W-1:0]    i_observed_transactions,
    input  logic [abl_pkg::BYTES_W-1:0] i_observed_bytes,
    input  logic [abl_pkg::PRESS_W-1:0] i_pressure,
    input  logic [abl_pkg::TX_W-1:0]    i_queue_depth,
    input  logic [abl_pkg::AGE_W-1:0]   i_oldest_age,
    input  logic                        i_done,
    input  logic [abl_pkg::TX_W-1:0]    i_limit_transactions,
    input  logic [abl_pkg::BYTES_W-1:0] i_limit_bytes,
    input  logic [abl_pkg::AGE_W-1:0]   i_limit_age,
    input  logic                        i_cfg_we,
    input  logic [abl_pkg::IDX_W-1:0]   i_cfg_addr,
    input  logic [abl_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_pending,
    output int                          o_failures,
    output int                          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import abl_pkg::*;

    typedef struct packed {
        logic [TX_W-1:0]    txns;
        logic [BYTES_W-1:0] bytes;
        logic [AGE_W-1:0]   age;
    } epoch_limits_t;

    localparam logic [BYTES_W-1:0] EWMA_WEIGHT = 32'd8;
    localparam logic [63:0]        HALVING     = 64'd2;
    localparam int                 PRINT_CAP   = 40;

    logic [TX_W-1:0]    max_tx_r;
    logic [BYTES_W-1:0] max_bytes_r;
    logic [AGE_W-1:0]   max_age_r;
    logic [AGE_W-1:0]   latency_r;
    logic [TX_W-1:0]    min_load_r;
    logic [TX_W-1:0]    deep_r;
    logic [BYTES_W-1:0] bytes_per_txn;
    logic [BYTES_W-1:0] sample;
    epoch_limits_t      want;
    epoch_limits_t      expected_limits[$];
    int                 fail_total    = 0;
    int                 checked_total = 0;

    task automatic report_mismatch(input string msg);
        fail_total++;
        if (fail_total <= PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    function automatic logic [63:0] larger(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [63:0] smaller(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    // average times batch size, capped, never zero
    function automatic logic [63:0] bytes_budget(input logic [63:0] txns,
                                                 input logic [63:0] cap);
        return larger(64'd1, smaller(cap, 64'(bytes_per_txn) * txns));
    endfunction

    function automatic epoch_limits_t size_epoch(input logic [PRESS_W-1:0] press,
                                                 input logic [TX_W-1:0]    depth,
                                                 input logic [AGE_W-1:0]   age);
        logic [63:0]   mtx, mbytes, mage, lat, mload, deep_th;
        logic [63:0]   ltx, lbytes, lage, depth64, age64;
        logic          is_deep;
        epoch_limits_t res;
        mtx     = larger(64'd1, 64'(max_tx_r));
        mbytes  = larger(64'd1, 64'(max_bytes_r));
        mage    = 64'(max_age_r);
        lat     = larger(64'd1, 64'(latency_r));
        mload   = smaller(mtx, larger(64'd1, 64'(min_load_r)));
        deep_th = larger(64'd1, 64'(deep_r));
        depth64 = 64'(depth);
        age64   = 64'(age);
        is_deep = 1'b0;
        if (press[PRESS_HARD_BIT]) begin
            ltx    = 64'd1;
            lbytes = smaller(mbytes, 64'(HARD_BYTES_CAP));
            lage   = 64'd0;
        end else if (press == PRESS_SOFT) begin
            ltx    = larger(64'd1, mtx / HALVING);
            lbytes = larger(64'd1, mbytes / HALVING);
            lage   = smaller(mage, 64'(SOFT_AGE_CAP));
        end else if (depth64 <= 64'd1) begin
            ltx    = 64'd1;
            lbytes = mbytes;
            lage   = (age64 > lat) ? 64'd0 : mage;
        end else begin
            is_deep = depth64 >= deep_th;
            ltx     = is_deep ? mtx : smaller(mtx, larger(mload, depth64));
            lbytes  = (bytes_per_txn != 0) ? bytes_budget(ltx, mbytes) : mbytes;
            lage    = mage;
            if (age64 > lat) begin
                // missed the latency target: halve, but hold the under-load floor
                ltx    = larger(mload, ltx / HALVING);
                lbytes = (bytes_per_txn != 0) ? bytes_budget(ltx, mbytes)
                                              : larger(64'd1, mbytes / HALVING);
                lage   = 64'd0;
            end else if (is_deep || depth64 >= ltx) begin
                lage = 64'd0;
            end
        end
        res.txns  = ltx[TX_W-1:0];
        res.bytes = lbytes[BYTES_W-1:0];
        res.age   = lage[AGE_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_tx_r      = RST_MAX_TX;
            max_bytes_r   = RST_MAX_BYTES;
            max_age_r     = RST_MAX_AGE;
            latency_r     = RST_LATENCY;
            min_load_r    = RST_MIN_LOAD;
            deep_r        = RST_DEEP;
            bytes_per_txn = '0;
            expected_limits.delete();
        end else begin
            if (i_done) begin
                if (expected_limits.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with no request waiting: tx=%0d bytes=%0d age=%0d",
                        i_limit_transactions, i_limit_bytes, i_limit_age));
                end else begin
                    want = expected_limits.pop_front();
                    checked_total++;
                    if (i_limit_transactions !== want.txns) begin
                        report_mismatch($sformatf("limit_transactions got %0d want %0d",
                                                  i_limit_transactions, want.txns));
                    end
                    if (i_limit_bytes !== want.bytes) begin
                        report_mismatch($sformatf("limit_bytes got %0d want %0d",
                                                  i_limit_bytes, want.bytes));
                    end
                    if (i_limit_age !== want.age) begin
                        report_mismatch($sformatf("limit_age got %0d want %0d",
                                                  i_limit_age, want.age));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAX_TX:    max_tx_r    = i_cfg_data[TX_W-1:0];
                    CFG_MAX_BYTES: max_bytes_r = i_cfg_data[BYTES_W-1:0];
                    CFG_MAX_AGE:   max_age_r   = i_cfg_data[AGE_W-1:0];
                    CFG_LATENCY:   latency_r   = i_cfg_data[AGE_W-1:0];
                    CFG_MIN_LOAD:  min_load_r  = i_cfg_data[TX_W-1:0];
                    CFG_DEEP:      deep_r      = i_cfg_data[TX_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_command == CMD_LIMITS) begin
                    expected_limits.push_back(size_epoch(i_pressure, i_queue_depth,
                                                         i_oldest_age));
                end else if (i_observed_transactions != 0) begin
                    sample = i_observed_bytes / i_observed_transactions;
                    // an empty average takes the first sample as is
                    if (bytes_per_txn == 0) begin
                        bytes_per_txn = sample;
                    end else begin
                        bytes_per_txn = bytes_per_txn - bytes_per_txn / EWMA_WEIGHT
                                      + sample / EWMA_WEIGHT;
                    end
                end
            end
        end
        o_pending  <= expected_limits.size();
        o_failures <= fail_total;
        o_checked  <= checked_total;
    end

endmodule

### tb/sv/tb.sv
// Top-level testbench for the adaptive batch limit controller: stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import abl_pkg::*;

    localparam int       CYCLE_LIMIT      = 600000;
    localparam int       RANDOM_PER_PHASE = 230;
    localparam int       N_SETTINGS       = 8;
    localparam int       SETTLE_CYCLES    = 40;
    localparam t_cfg_idx CFG_UNMAPPED_LO  = 3'd6;
    localparam t_cfg_idx CFG_UNMAPPED_HI  = 3'd7;

    localparam logic [PRESS_W-1:0] PRESS_NONE = 2'd0;
    localparam logic [PRESS_W-1:0] PRESS_HARD = 2'd2;
    localparam logic [PRESS_W-1:0] PRESS_BOTH = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_command;
    logic [TX_W-1:0]    i_observed_transactions;
    logic [BYTES_W-1:0] i_observed_bytes;
    logic [PRESS_W-1:0] i_pressure;
    logic [TX_W-1:0]    i_queue_depth;
    logic [AGE_W-1:0]   i_oldest_age;
    logic               o_done;
    logic [TX_W-1:0]    o_limit_transactions;
    logic [BYTES_W-1:0] o_limit_bytes;
    logic [AGE_W-1:0]   o_limit_age;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_addr;
    logic [CFG_W-1:0]   i_cfg_data;

    int                 pending_results;
    int                 failures;
    int                 results_checked;
    int                 cycle_count = 0;
    int                 n_observe   = 0;
    int                 n_limits    = 0;
    int                 burst_left  = 0;
    int                 gap;
    logic [CFG_W-1:0]   cfg_shadow [0:5];

    adaptive_batch_limit_controller_unit DUT (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_start                 (i_start),
        .o_busy                  (o_busy),
        .i_command               (i_command),
        .i_observed_transactions (i_observed_transactions),
        .i_observed_bytes        (i_observed_bytes),
        .i_pressure              (i_pressure),
        .i_queue_depth           (i_queue_depth),
        .i_oldest_age            (i_oldest_age),
        .o_done                  (o_done),
        .o_limit_transactions    (o_limit_transactions),
        .o_limit_bytes           (o_limit_bytes),
        .o_limit_age             (o_limit_age),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_addr              (i_cfg_addr),
        .i_cfg_data              (i_cfg_data)
    );

    abl_limit_check u_check (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_start                 (i_start),
        .i_busy                  (o_busy),
        .i_command               (i_command),
        .i_observed_transactions (i_observed_transactions),
        .i_observed_bytes        (i_observed_bytes),
        .i_pressure              (i_pressure),
        .i_queue_depth           (i_queue_depth),
        .i_oldest_age            (i_oldest_age),
        .i_done                  (o_done),
        .i_limit_transactions    (o_limit_transactions),
        .i_limit_bytes           (o_limit_bytes),
        .i_limit_age             (o_limit_age),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_addr              (i_cfg_addr),
        .i_cfg_data              (i_cfg_data),
        .o_pending               (pending_results),
        .o_failures              (failures),
        .o_checked               (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results);
            $display("simulation failed");
            $finish;
        end
    end

    // present one beat and hold it until the block takes it
    task automatic send_beat(input logic               cmd,
                             input logic [TX_W-1:0]    otx,
                             input logic [BYTES_W-1:0] obytes,
                             input logic [PRESS_W-1:0] press,
                             input logic [TX_W-1:0]    depth,
                             input logic [AGE_W-1:0]   age);
        i_start                 <= 1'b1;
        i_command               <= cmd;
        i_observed_transactions <= otx;
        i_observed_bytes        <= obytes;
        i_pressure              <= press;
        i_queue_depth           <= depth;
        i_oldest_age            <= age;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (cmd == CMD_LIMITS) n_limits++;
        else n_observe++;
    endtask

    task automatic wait_for_drain(input int settle);
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0 || o_busy);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        if (idx <= CFG_DEEP) cfg_shadow[idx] = data;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] random_setting();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 16);
            2:       return $urandom_range(17, 4096);
            default: return $urandom_range(4097, 1 << 20);
        endcase
    endfunction

    task automatic apply_setting(input int setting);
        logic [CFG_W-1:0] vals [0:5];
        case (setting)
            1: vals = '{32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF};
            // zeros and dropped upper bits: all but the age limit clamp to their floors
            2: vals = '{32'hFFFF_0000, 32'd0, 32'd0, 32'd0, 32'h1234_0000, 32'hABCD_0000};
            // under-load floor above the transaction cap
            3: vals = '{32'd8, 32'd1000, 32'd30, 32'd200, 32'd20, 32'd4};
            N_SETTINGS - 1: vals = '{32'(RST_MAX_TX), RST_MAX_BYTES, RST_MAX_AGE,
                                     RST_LATENCY, 32'(RST_MIN_LOAD), 32'(RST_DEEP)};
            default: begin
                for (int r = 0; r < 6; r++) vals[r] = random_setting();
            end
        endcase
        for (int r = 0; r < 6; r++) cfg_write(t_cfg_idx'(r), vals[r]);
        if (setting == 1) begin
            cfg_write(CFG_UNMAPPED_LO, $urandom());
            cfg_write(CFG_UNMAPPED_HI, $urandom());
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_beat();
        logic               cmd;
        logic [TX_W-1:0]    otx;
        logic [BYTES_W-1:0] obytes;
        logic [PRESS_W-1:0] press;
        logic [TX_W-1:0]    depth;
        logic [AGE_W-1:0]   age;
        logic [TX_W-1:0]    deep_th;
        logic [TX_W-1:0]    mtx;
        logic [AGE_W-1:0]   lat;
        lat     = (cfg_shadow[CFG_LATENCY] == 0) ? 32'd1 : cfg_shadow[CFG_LATENCY];
        deep_th = (cfg_shadow[CFG_DEEP][TX_W-1:0] == 0) ? 16'd1 : cfg_shadow[CFG_DEEP][TX_W-1:0];
        mtx     = (cfg_shadow[CFG_MAX_TX][TX_W-1:0] == 0) ? 16'd1
                                                          : cfg_shadow[CFG_MAX_TX][TX_W-1:0];
        cmd = ($urandom_range(0, 9) < 4) ? CMD_OBSERVE : CMD_LIMITS;
        case ($urandom_range(0, 9))
            0:       otx = '0;
            1:       otx = 16'd1;
            2:       otx = 16'hFFFF;
            3, 4:    otx = TX_W'($urandom_range(1, 65535));
            default: otx = TX_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
            0, 1:    obytes = $urandom();
            2:       obytes = 32'hFFFF_FFFF;
            3:       obytes = $urandom_range(0, 200000);
            default: obytes = otx * $urandom_range(0, 5000);
        endcase
        case ($urandom_range(0, 9))
            6, 7:    press = PRESS_SOFT;
            8:       press = PRESS_HARD;
            9:       press = PRESS_BOTH;
            default: press = PRESS_NONE;
        endcase
        case ($urandom_range(0, 9))
            0:       depth = TX_W'($urandom_range(0, 1));
            1, 2:    depth = TX_W'($urandom_range(2, 8));
            3, 4:    depth = TX_W'(deep_th + $urandom_range(0, 2) - 1);
            5:       depth = TX_W'(mtx + $urandom_range(0, 2) - 1);
            6:       depth = 16'hFFFF;
            default: depth = TX_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       age = '0;
            1, 2:    age = lat + $urandom_range(0, 2) - 1;
            3:       age = 32'hFFFF_FFFF;
            4, 5, 6: age = $urandom_range(0, lat);
            default: age = $urandom();
        endcase
        send_beat(cmd, otx, obytes, press, depth, age);
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        i_start                 = 1'b0;
        i_command               = CMD_OBSERVE;
        i_observed_transactions = '0;
        i_observed_bytes        = '0;
        i_pressure              = PRESS_NONE;
        i_queue_depth           = '0;
        i_oldest_age            = '0;
        i_cfg_we                = 1'b0;
        i_cfg_addr              = CFG_MAX_TX;
        i_cfg_data              = '0;
        cfg_shadow = '{32'(RST_MAX_TX), RST_MAX_BYTES, RST_MAX_AGE,
                       RST_LATENCY, 32'(RST_MIN_LOAD), 32'(RST_DEEP)};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers, average still empty
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_HARD, 16'd5,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_BOTH, 16'd5,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_SOFT, 16'd5,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd0,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd1,     32'd1001);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd8,     32'd1000);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd8,     32'd2000);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd16,    32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'hFFFF,  32'hFFFF_FFFF);
        // zero transactions: drop the sample
        send_beat(CMD_OBSERVE, 16'd0,     32'hFFFF_FFFF,  PRESS_NONE, 16'd0,     32'd0);
        // zero sample keeps the average empty
        send_beat(CMD_OBSERVE, 16'hFFFF,  32'd100,        PRESS_NONE, 16'd0,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd3,     32'd0);
        send_beat(CMD_OBSERVE, 16'd1,     32'hFFFF_FFFF,  PRESS_NONE, 16'd0,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd64,    32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd10,    32'd5000);
        send_beat(CMD_OBSERVE, 16'd3,     32'd3000,       PRESS_NONE, 16'd0,     32'd0);
        send_beat(CMD_OBSERVE, 16'hFFFF,  32'd0,          PRESS_NONE, 16'd0,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd2,     32'd0);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_NONE, 16'd5,     32'd0);
        send_beat(CMD_LIMITS,  16'hFFFF,  32'hFFFF_FFFF,  PRESS_NONE, 16'd6,     32'd0);
        send_beat(CMD_OBSERVE, 16'd7,     32'd12345,      PRESS_BOTH, 16'hFFFF,  32'hFFFF_FFFF);
        send_beat(CMD_LIMITS,  16'd0,     32'd0,          PRESS_SOFT, 16'd0,     32'd0);

        for (int setting = 0; setting < N_SETTINGS; setting++) begin
            if (setting > 0) begin
                wait_for_drain(SETTLE_CYCLES);
                apply_setting(setting);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // hold off once per phase until every result is back
                if (n == RANDOM_PER_PHASE / 2) wait_for_drain(0);
                random_beat();
                if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else if ($urandom_range(0, 49) == 0) begin
                    burst_left = 40;
                    gap = 0;
                end else begin
                    case ($urandom_range(0, 19))
                        10, 11, 12, 13, 14, 15, 16: gap = $urandom_range(1, 3);
                        17, 18:                     gap = $urandom_range(4, 10);
                        19:                         gap = $urandom_range(20, 60);
                        default:                    gap = 0;
                    endcase
                end
                if (gap > 0) begin
                    i_start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        wait_for_drain(SETTLE_CYCLES);

        $display("covered %0d command beats (%0d observe, %0d limits) over %0d register settings",
                 n_observe + n_limits, n_observe, n_limits, N_SETTINGS);
        $display("compared %0d limit results, %0d mismatches", results_checked, failures);
        if (failures == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
